// File: rtl/core/rti_pkg.sv
`default_nettype none
package rti_pkg;

   localparam int COORD_BITS = 32;
   localparam int TAG_BITS = 16;
   localparam int EDGE_BITS = COORD_BITS + 1;
   localparam int CROSS_BITS = 2 * EDGE_BITS + 1;
   localparam int DOT_BITS = EDGE_BITS + CROSS_BITS + 2;
   localparam int SCALE_BITS = DOT_BITS + 17;
   localparam int QUO_BITS = 34;
   localparam int DIST_BITS = 33;
   localparam int REM_BITS = DOT_BITS + QUO_BITS;
   localparam int CSR_INDEX_BITS = 3;
   localparam int LATENCY = 45;

   localparam logic [CSR_INDEX_BITS-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIR_X = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIR_Y = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DIR_Z = 3'd5;

   localparam logic signed [COORD_BITS-1:0] DIR_Z_RESET = COORD_BITS'(65536);
   localparam logic signed [DOT_BITS-1:0] DET_EPS = DOT_BITS'(64'd2814749767);
   localparam logic [DIST_BITS-1:0] DIST_LIMIT = DIST_BITS'(64'd6553600000);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [EDGE_BITS-1:0] edge_type;
   typedef logic signed [CROSS_BITS-1:0] cross_type;
   typedef logic signed [DOT_BITS-1:0] dot_type;
   typedef logic signed [SCALE_BITS-1:0] scale_type;

   typedef struct packed {
      logic [TAG_BITS-1:0] tri_tag;
      logic signed [COORD_BITS-1:0] v0_x;
      logic signed [COORD_BITS-1:0] v0_y;
      logic signed [COORD_BITS-1:0] v0_z;
      logic signed [COORD_BITS-1:0] v1_x;
      logic signed [COORD_BITS-1:0] v1_y;
      logic signed [COORD_BITS-1:0] v1_z;
      logic signed [COORD_BITS-1:0] v2_x;
      logic signed [COORD_BITS-1:0] v2_y;
      logic signed [COORD_BITS-1:0] v2_z;
   } req_type;

   typedef struct packed {
      logic [TAG_BITS-1:0] out_tag;
      logic hit;
      logic [DIST_BITS-1:0] hit_distance;
   } rsp_type;

   // Multiplies by 100000 as a sum of six shifted copies.
   function automatic scale_type eps_scale(input dot_type x);
      scale_type w;
      begin
         w = SCALE_BITS'(x);
         return (w <<< 16) + (w <<< 15) + (w <<< 10) + (w <<< 9) + (w <<< 7) + (w <<< 5);
      end
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/rti_mul.sv
`default_nettype none
module rti_mul #(
   parameter int A_BITS = 33,
   parameter int B_BITS = 33
) (
   input  logic                             clock,
   input  logic signed [A_BITS-1:0]         a,
   input  logic signed [B_BITS-1:0]         b,
   output logic signed [A_BITS+B_BITS-1:0]  p
);

   localparam int LIMB = 32;
   localparam int NA = (A_BITS + LIMB - 1) / LIMB;
   localparam int NB = (B_BITS + LIMB - 1) / LIMB;
   localparam int P_BITS = A_BITS + B_BITS;

   logic signed [NA*LIMB-1:0] a_ext;
   logic signed [NB*LIMB-1:0] b_ext;
   logic signed [LIMB:0] a_limb [NA];
   logic signed [LIMB:0] b_limb [NB];
   logic signed [2*LIMB+1:0] pp_ff [NA][NB];
   logic signed [P_BITS-1:0] acc;
   logic signed [P_BITS-1:0] p_ff;

   assign a_ext = (NA*LIMB)'(a);
   assign b_ext = (NB*LIMB)'(b);

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         a_limb[i] = {((i == NA - 1) ? a_ext[NA*LIMB-1] : 1'b0), a_ext[i*LIMB +: LIMB]};
      end
      for (int j = 0; j < NB; j++) begin
         b_limb[j] = {((j == NB - 1) ? b_ext[NB*LIMB-1] : 1'b0), b_ext[j*LIMB +: LIMB]};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_ff[i][j] <= a_limb[i] * b_limb[j];
         end
      end
   end

   always_comb begin
      acc = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            acc = acc + (P_BITS'(pp_ff[i][j]) <<< (LIMB * (i + j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= acc;
   end

   assign p = p_ff;

endmodule
`default_nettype wire

// File: rtl/core/ray_triangle_intersect_top.sv
`default_nettype none
// Ray/triangle intersection unit (Moller-Trumbore, exact fixed point).
// The ray is held in six registers written through the csr_ port: origin
// x, y, z at indexes 0 to 2 and direction x, y, z at indexes 3 to 5, each
// signed Q16.16. Write them only while no triangle is in flight.
// A triangle beat is taken at each clock edge where start is high and busy
// is low; busy is high only during reset, so one triangle is taken per cycle.
// Every triangle produces exactly one result beat, shown for one cycle with
// rsp_valid high. The pipeline holds, in order: edge subtract, two pipelined
// multiplies with their sums, sign fix, range tests and a 34-stage restoring
// divider for the distance. Results leave in input order.
// The receiver cannot stall the unit.
// Reset clears the ray to origin zero and direction +z and drops every
// triangle in flight; no result beat follows a reset.
module ray_triangle_intersect_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  rti_pkg::req_type                      req_item,
   output logic                                  rsp_valid,
   output rti_pkg::rsp_type                      rsp_item,
   input  logic                                  csr_we,
   input  logic [rti_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [rti_pkg::COORD_BITS-1:0]        csr_wdata
);

   localparam int LAT = rti_pkg::LATENCY;
   localparam int DIV_STAGES = rti_pkg::QUO_BITS;
   localparam int EW = rti_pkg::EDGE_BITS;
   localparam int XW = rti_pkg::CROSS_BITS;
   localparam int DW = rti_pkg::DOT_BITS;
   localparam int RW = rti_pkg::REM_BITS;
   localparam int QW = rti_pkg::QUO_BITS;

   rti_pkg::coord_type org_ff [3];
   rti_pkg::coord_type dir_ff [3];

   logic accept;
   logic [LAT-1:0] vld_ff;
   logic [rti_pkg::TAG_BITS-1:0] tag_ff [LAT-1];

   rti_pkg::coord_type v0 [3];
   rti_pkg::coord_type v1 [3];
   rti_pkg::coord_type v2 [3];
   rti_pkg::edge_type e1_ff [3];
   rti_pkg::edge_type e2_ff [3];
   rti_pkg::edge_type s_ff [3];
   rti_pkg::edge_type e1_dly_ff [3][3];
   rti_pkg::edge_type e2_dly_ff [3][3];
   rti_pkg::edge_type s_dly_ff [3][3];

   logic signed [2*EW-1:0] pa [3];
   logic signed [2*EW-1:0] pb [3];
   logic signed [2*EW-1:0] qa [3];
   logic signed [2*EW-1:0] qb [3];
   rti_pkg::cross_type pv_ff [3];
   rti_pkg::cross_type qv_ff [3];

   logic signed [EW+XW-1:0] det_t [3];
   logic signed [EW+XW-1:0] nu_t [3];
   logic signed [EW+XW-1:0] nv_t [3];
   logic signed [EW+XW-1:0] nt_t [3];

   rti_pkg::dot_type det_ff, nu_ff, nv_ff, nt_ff;
   rti_pkg::dot_type det_fx_ff, nu_fx_ff, nv_fx_ff, nt_fx_ff;
   rti_pkg::dot_type det9_ff, nt9_ff;
   rti_pkg::scale_type ntei_ff, detei_ff;
   logic small_ff, outside_ff;

   logic [RW-1:0] rem_ff [DIV_STAGES+1];
   logic [DW-1:0] dv_ff [DIV_STAGES+1];
   logic [QW-1:0] q_ff [DIV_STAGES+1];
   logic hit_ff [DIV_STAGES+1];

   rti_pkg::rsp_type rsp_ff;

   assign busy = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff[0] <= '0;
         org_ff[1] <= '0;
         org_ff[2] <= '0;
         dir_ff[0] <= '0;
         dir_ff[1] <= '0;
         dir_ff[2] <= rti_pkg::DIR_Z_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rti_pkg::REG_ORIGIN_X: org_ff[0] <= csr_wdata;
            rti_pkg::REG_ORIGIN_Y: org_ff[1] <= csr_wdata;
            rti_pkg::REG_ORIGIN_Z: org_ff[2] <= csr_wdata;
            rti_pkg::REG_DIR_X: dir_ff[0] <= csr_wdata;
            rti_pkg::REG_DIR_Y: dir_ff[1] <= csr_wdata;
            rti_pkg::REG_DIR_Z: dir_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= req_item.tri_tag;
      for (int n = 1; n < LAT - 1; n++) begin
         tag_ff[n] <= tag_ff[n-1];
      end
   end

   assign v0[0] = req_item.v0_x;
   assign v0[1] = req_item.v0_y;
   assign v0[2] = req_item.v0_z;
   assign v1[0] = req_item.v1_x;
   assign v1[1] = req_item.v1_y;
   assign v1[2] = req_item.v1_z;
   assign v2[0] = req_item.v2_x;
   assign v2[1] = req_item.v2_y;
   assign v2[2] = req_item.v2_z;

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         e1_ff[j] <= EW'(v1[j]) - EW'(v0[j]);
         e2_ff[j] <= EW'(v2[j]) - EW'(v0[j]);
         s_ff[j] <= EW'(org_ff[j]) - EW'(v0[j]);
         e1_dly_ff[0][j] <= e1_ff[j];
         e2_dly_ff[0][j] <= e2_ff[j];
         s_dly_ff[0][j] <= s_ff[j];
         for (int d = 1; d < 3; d++) begin
            e1_dly_ff[d][j] <= e1_dly_ff[d-1][j];
            e2_dly_ff[d][j] <= e2_dly_ff[d-1][j];
            s_dly_ff[d][j] <= s_dly_ff[d-1][j];
         end
      end
   end

   for (genvar j = 0; j < 3; j++) begin : g_cross
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;

      rti_mul #(.A_BITS(EW), .B_BITS(EW)) u_pa (
         .clock(clock), .a(EW'(dir_ff[J1])), .b(e2_ff[J2]), .p(pa[j]));
      rti_mul #(.A_BITS(EW), .B_BITS(EW)) u_pb (
         .clock(clock), .a(EW'(dir_ff[J2])), .b(e2_ff[J1]), .p(pb[j]));
      rti_mul #(.A_BITS(EW), .B_BITS(EW)) u_qa (
         .clock(clock), .a(s_ff[J1]), .b(e1_ff[J2]), .p(qa[j]));
      rti_mul #(.A_BITS(EW), .B_BITS(EW)) u_qb (
         .clock(clock), .a(s_ff[J2]), .b(e1_ff[J1]), .p(qb[j]));

      always_ff @(posedge clock) begin
         pv_ff[j] <= XW'(pa[j]) - XW'(pb[j]);
         qv_ff[j] <= XW'(qa[j]) - XW'(qb[j]);
      end

      rti_mul #(.A_BITS(EW), .B_BITS(XW)) u_det (
         .clock(clock), .a(e1_dly_ff[2][j]), .b(pv_ff[j]), .p(det_t[j]));
      rti_mul #(.A_BITS(EW), .B_BITS(XW)) u_nu (
         .clock(clock), .a(s_dly_ff[2][j]), .b(pv_ff[j]), .p(nu_t[j]));
      rti_mul #(.A_BITS(EW), .B_BITS(XW)) u_nv (
         .clock(clock), .a(EW'(dir_ff[j])), .b(qv_ff[j]), .p(nv_t[j]));
      rti_mul #(.A_BITS(EW), .B_BITS(XW)) u_nt (
         .clock(clock), .a(e2_dly_ff[2][j]), .b(qv_ff[j]), .p(nt_t[j]));
   end

   always_ff @(posedge clock) begin
      det_ff <= DW'(det_t[0]) + DW'(det_t[1]) + DW'(det_t[2]);
      nu_ff <= DW'(nu_t[0]) + DW'(nu_t[1]) + DW'(nu_t[2]);
      nv_ff <= DW'(nv_t[0]) + DW'(nv_t[1]) + DW'(nv_t[2]);
      nt_ff <= DW'(nt_t[0]) + DW'(nt_t[1]) + DW'(nt_t[2]);
   end

   always_ff @(posedge clock) begin
      if (det_ff[DW-1]) begin
         det_fx_ff <= -det_ff;
         nu_fx_ff <= -nu_ff;
         nv_fx_ff <= -nv_ff;
         nt_fx_ff <= -nt_ff;
      end else begin
         det_fx_ff <= det_ff;
         nu_fx_ff <= nu_ff;
         nv_fx_ff <= nv_ff;
         nt_fx_ff <= nt_ff;
      end
   end

   always_ff @(posedge clock) begin
      small_ff <= det_fx_ff <= rti_pkg::DET_EPS;
      outside_ff <= nu_fx_ff[DW-1] || (nu_fx_ff > det_fx_ff) || nv_fx_ff[DW-1]
                    || ((DW+1)'(nu_fx_ff) + (DW+1)'(nv_fx_ff) > (DW+1)'(det_fx_ff));
      ntei_ff <= rti_pkg::eps_scale(nt_fx_ff);
      detei_ff <= rti_pkg::eps_scale(det_fx_ff);
      det9_ff <= det_fx_ff;
      nt9_ff <= nt_fx_ff;
   end

   always_ff @(posedge clock) begin
      hit_ff[0] <= !small_ff && !outside_ff && (ntei_ff > rti_pkg::SCALE_BITS'(det9_ff))
                   && (rti_pkg::SCALE_BITS'(nt9_ff) < detei_ff);
      rem_ff[0] <= RW'($unsigned(nt9_ff)) << 16;
      dv_ff[0] <= $unsigned(det9_ff);
      q_ff[0] <= '0;
   end

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      localparam int K = DIV_STAGES - 1 - g;
      logic [RW-1:0] shifted;
      logic ge;

      assign shifted = RW'(dv_ff[g]) << K;
      assign ge = rem_ff[g] >= shifted;

      always_ff @(posedge clock) begin
         rem_ff[g+1] <= ge ? rem_ff[g] - shifted : rem_ff[g];
         q_ff[g+1] <= q_ff[g] | (QW'(ge) << K);
         dv_ff[g+1] <= dv_ff[g];
         hit_ff[g+1] <= hit_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.out_tag <= tag_ff[LAT-2];
      rsp_ff.hit <= hit_ff[DIV_STAGES];
      rsp_ff.hit_distance <= hit_ff[DIV_STAGES] ? q_ff[DIV_STAGES][rti_pkg::DIST_BITS-1:0]
                                                 : '0;
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_item = rsp_ff;

endmodule
`default_nettype wire

// File: rtl/core/rti_checker.sv
`default_nettype none
module rti_checker #(
   parameter int LATENCY = 45
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input rti_pkg::rsp_type rsp_item
);

   // No result beat may appear in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // Every accepted triangle gives a result beat after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result beat missing");

   // A result beat always matches an accepted triangle.
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result beat without triangle");

   // A miss reports zero distance.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.hit) |-> (rsp_item.hit_distance == '0))
      else $error("nonzero distance on miss");

   // A hit lies below the far limit.
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.hit) |-> (rsp_item.hit_distance < rti_pkg::DIST_LIMIT))
      else $error("hit distance out of range");

endmodule

bind ray_triangle_intersect_top rti_checker #(.LATENCY(rti_pkg::LATENCY)) u_rti_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_item(rsp_item)
);
`default_nettype wire

// File: tb/ray_triangle_intersect_checker.sv
`timescale 1ns / 100ps
module ray_triangle_intersect_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  rti_pkg::req_type                   req_item,
   input  logic                               rsp_valid,
   input  rti_pkg::rsp_type                   rsp_item,
   input  logic                               csr_we,
   input  logic [rti_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rti_pkg::COORD_BITS-1:0]     csr_wdata,
   output int                                 fail_count,
   output int                                 pending
);

   typedef logic signed [255:0] wide_type;

   rti_pkg::coord_type ray_org [3];
   rti_pkg::coord_type ray_dir [3];
   rti_pkg::rsp_type   want_mem [64];
   logic [5:0]         wr_ptr;
   logic [5:0]         rd_ptr;
   int                 count = 0;

   initial fail_count = 0;

   assign pending = count;

   task automatic report(input string what, input rti_pkg::rsp_type got,
                         input rti_pkg::rsp_type want);
      $display("mismatch %s: got tag %h hit %b dist %h, want tag %h hit %b dist %h", what,
               got.out_tag, got.hit, got.hit_distance, want.out_tag, want.hit,
               want.hit_distance);
      fail_count++;
   endtask

   function automatic rti_pkg::rsp_type predict(input rti_pkg::req_type t);
      wide_type e1 [3];
      wide_type e2 [3];
      wide_type sv [3];
      wide_type dv [3];
      wide_type pv [3];
      wide_type qv [3];
      wide_type det, nu, nv, nt, quo;
      logic  hit;
      rti_pkg::rsp_type r;
      e1[0] = wide_type'(t.v1_x) - wide_type'(t.v0_x);
      e1[1] = wide_type'(t.v1_y) - wide_type'(t.v0_y);
      e1[2] = wide_type'(t.v1_z) - wide_type'(t.v0_z);
      e2[0] = wide_type'(t.v2_x) - wide_type'(t.v0_x);
      e2[1] = wide_type'(t.v2_y) - wide_type'(t.v0_y);
      e2[2] = wide_type'(t.v2_z) - wide_type'(t.v0_z);
      sv[0] = wide_type'(ray_org[0]) - wide_type'(t.v0_x);
      sv[1] = wide_type'(ray_org[1]) - wide_type'(t.v0_y);
      sv[2] = wide_type'(ray_org[2]) - wide_type'(t.v0_z);
      for (int k = 0; k < 3; k++) dv[k] = wide_type'(ray_dir[k]);
      pv[0] = dv[1] * e2[2] - dv[2] * e2[1];
      pv[1] = dv[2] * e2[0] - dv[0] * e2[2];
      pv[2] = dv[0] * e2[1] - dv[1] * e2[0];
      qv[0] = sv[1] * e1[2] - sv[2] * e1[1];
      qv[1] = sv[2] * e1[0] - sv[0] * e1[2];
      qv[2] = sv[0] * e1[1] - sv[1] * e1[0];
      det = e1[0] * pv[0] + e1[1] * pv[1] + e1[2] * pv[2];
      nu = sv[0] * pv[0] + sv[1] * pv[1] + sv[2] * pv[2];
      nv = dv[0] * qv[0] + dv[1] * qv[1] + dv[2] * qv[2];
      nt = e2[0] * qv[0] + e2[1] * qv[1] + e2[2] * qv[2];
      if (det < 0) begin
         det = -det;
         nu = -nu;
         nv = -nv;
         nt = -nt;
      end
      hit = det > wide_type'(64'd2814749767);
      if (hit && (nu < 0 || nu > det || nv < 0 || nu + nv > det)) hit = 1'b0;
      if (hit && (nt * 100000 <= det || nt >= det * 100000)) hit = 1'b0;
      quo = hit ? (nt <<< 16) / det : '0;
      r.out_tag = t.tri_tag;
      r.hit = hit;
      r.hit_distance = quo[rti_pkg::DIST_BITS-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rti_pkg::rsp_type want;
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            ray_org[k] = '0;
            ray_dir[k] = '0;
         end
         ray_dir[2] = rti_pkg::DIR_Z_RESET;
         wr_ptr = '0;
         rd_ptr = '0;
         count = 0;
      end else begin
         if (rsp_valid) begin
            if (count == 0) begin
               report("unexpected beat", rsp_item, '0);
            end else begin
               want = want_mem[rd_ptr];
               rd_ptr = rd_ptr + 6'd1;
               count--;
               if (rsp_item.out_tag !== want.out_tag) report("out_tag", rsp_item, want);
               if (rsp_item.hit !== want.hit) report("hit", rsp_item, want);
               if (rsp_item.hit_distance !== want.hit_distance)
                  report("hit_distance", rsp_item, want);
            end
         end
         if (start && !busy) begin
            want_mem[wr_ptr] = predict(req_item);
            wr_ptr = wr_ptr + 6'd1;
            count++;
         end
         if (csr_we) begin
            case (csr_index)
               rti_pkg::REG_ORIGIN_X: ray_org[0] = csr_wdata;
               rti_pkg::REG_ORIGIN_Y: ray_org[1] = csr_wdata;
               rti_pkg::REG_ORIGIN_Z: ray_org[2] = csr_wdata;
               rti_pkg::REG_DIR_X: ray_dir[0] = csr_wdata;
               rti_pkg::REG_DIR_Y: ray_dir[1] = csr_wdata;
               rti_pkg::REG_DIR_Z: ray_dir[2] = csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

// File: tb/ray_triangle_intersect_top_tb.sv
`timescale 1ns / 100ps
module ray_triangle_intersect_top_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ONE = 65536;
   localparam logic [rti_pkg::CSR_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
   localparam logic [rti_pkg::CSR_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;

   logic                               clock;
   logic                               reset;
   logic                               start;
   logic                               busy;
   rti_pkg::req_type                   req_item;
   logic                               rsp_valid;
   rti_pkg::rsp_type                   rsp_item;
   logic                               csr_we;
   logic [rti_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [rti_pkg::COORD_BITS-1:0]     csr_wdata;
   int                                 fail_count;
   int                                 pending;
   int                                 cycles;
   int                                 ray_o [3];
   int                                 ray_d [3];
   bit                                 no_gaps;

   ray_triangle_intersect_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   ray_triangle_intersect_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send(input rti_pkg::req_type x);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_item <= x;
      while (busy) @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (rti_pkg::LATENCY + 5) @(negedge clock);
   endtask

   task automatic csr_write(input logic [rti_pkg::CSR_INDEX_BITS-1:0] idx, input int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_ray(input int ox, oy, oz, dx, dy, dz);
      csr_write(rti_pkg::REG_ORIGIN_X, ox);
      csr_write(rti_pkg::REG_ORIGIN_Y, oy);
      csr_write(rti_pkg::REG_ORIGIN_Z, oz);
      csr_write(rti_pkg::REG_DIR_X, dx);
      csr_write(rti_pkg::REG_DIR_Y, dy);
      csr_write(rti_pkg::REG_DIR_Z, dz);
      ray_o = '{ox, oy, oz};
      ray_d = '{dx, dy, dz};
   endtask

   function automatic rti_pkg::req_type make_tri(input logic [15:0] tag, input int a [9]);
      rti_pkg::req_type t;
      t = '{tag, a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8]};
      return t;
   endfunction

   function automatic int jitter(input int spread);
      return int'($urandom_range(0, 2 * spread)) - spread;
   endfunction

   // A triangle placed around a point on the ray, so that many of these hit.
   function automatic rti_pkg::req_type ray_tri();
      int a [9];
      int k, spread;
      k = $urandom_range(0, 60) - 5;
      spread = 1 << $urandom_range(4, 20);
      for (int v = 0; v < 3; v++)
         for (int c = 0; c < 3; c++) a[3 * v + c] = ray_o[c] + k * ray_d[c] + jitter(spread);
      return make_tri(16'($urandom), a);
   endfunction

   function automatic rti_pkg::req_type noise_tri();
      int a [9];
      int sel;
      sel = $urandom_range(0, 2);
      for (int i = 0; i < 9; i++)
         a[i] = (sel == 0) ? int'($urandom) : (sel == 1) ? jitter(1 << 20) : jitter(64);
      return make_tri(16'($urandom), a);
   endfunction

   task automatic random_phase(input int n);
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 7) send(ray_tri());
         else send(noise_tri());
      end
      no_gaps = 1'b0;
      drain();
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      no_gaps = 1'b0;
      ray_o = '{0, 0, 0};
      ray_d = '{0, 0, ONE};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(make_tri(16'h0000, '{-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE}));
      send(make_tri(16'hFFFF, '{0, 0, 5 * ONE, ONE, 0, 5 * ONE, 0, ONE, 5 * ONE}));
      send(make_tri(16'h1234, '{ONE, 0, 2 * ONE, 0, ONE, 2 * ONE, ONE, ONE, 2 * ONE}));
      send(make_tri(16'h0001, '{-ONE, -ONE, 1, ONE, -ONE, 1, 0, ONE, 1}));
      send(make_tri(16'h0002, '{-ONE, -ONE, -ONE, ONE, -ONE, -ONE, 0, ONE, -ONE}));
      send(make_tri(16'h0003, '{0, 0, 0, 0, ONE, ONE, 0, ONE, 3 * ONE}));
      send(make_tri(16'h0004, '{0, 0, 0, 0, 0, 0, 0, 0, 0}));
      send(make_tri(16'h0005, '{-1, -1, -1, -1, -1, -1, -1, -1, -1}));
      send(make_tri(16'h0006, '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                                32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                                32'h7FFFFFFF}));
      send(make_tri(16'h0007, '{32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                32'h80000000, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 32'h7FFFFFFF}));
      send(make_tri(16'h0008, '{-8, -8, 3, 8, -8, 3, 0, 8, 3}));
      drain();

      csr_write(REG_SPARE_A, 32'h7FFFFFFF);
      csr_write(REG_SPARE_B, 32'h80000000);
      send(make_tri(16'h0009, '{-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE}));
      drain();
      set_ray(0, 0, 0, 0, 0, 1);
      send(make_tri(16'h000A, '{-ONE, -ONE, 2 * ONE, ONE, -ONE, 2 * ONE, 0, ONE, 2 * ONE}));
      send(make_tri(16'h000B, '{-ONE, -ONE, 20, ONE, -ONE, 20, 0, ONE, 20}));
      drain();
      set_ray(0, 0, 0, 0, 0, 0);
      send(make_tri(16'h000C, '{-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE}));
      drain();

      set_ray(0, 0, 0, 0, 0, ONE);
      random_phase(150);
      set_ray(jitter(10 * ONE), jitter(10 * ONE), jitter(10 * ONE),
              jitter(2 * ONE), jitter(2 * ONE), jitter(2 * ONE));
      random_phase(150);
      set_ray(jitter(ONE), jitter(ONE), jitter(ONE), jitter(64), jitter(64), jitter(64));
      random_phase(150);
      set_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h7FFFFFFF);
      random_phase(80);
      set_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
              32'h80000000);
      random_phase(80);
      set_ray(jitter(1000 * ONE), jitter(1000 * ONE), jitter(1000 * ONE),
              jitter(ONE / 2), jitter(ONE / 2), jitter(ONE / 2));
      random_phase(150);

      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/rti_pkg.sv
rtl/core/rti_mul.sv
rtl/core/ray_triangle_intersect_top.sv
rtl/core/rti_checker.sv
tb/ray_triangle_intersect_checker.sv
tb/ray_triangle_intersect_top_tb.sv
